FILE: hw/rtl/dlrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal LSD radix sort package
// Shared defaults, request codes and small types of the decimal radix sorter.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VALUE_BITS_DEF   = 31;
  localparam int RADIX            = 10;
  localparam int DIGIT_BITS       = 4;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef logic [DIGIT_BITS-1:0] digit_t;

endpackage

FILE: hw/rtl/dlrs_bcd_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Iterative shift-and-add-3 unit: one input bit per cycle, VALUE_BITS steps.
// ----------------------------------------------------------------------------
module dlrs_bcd_conv #(
  parameter int VALUE_BITS = dlrs_pkg::VALUE_BITS_DEF,
  parameter int BCD_BITS   = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] bin_i,
  output logic                  done_o,
  output logic [BCD_BITS-1:0]   bcd_o
);

  localparam int STEP_W  = $clog2(VALUE_BITS + 1);
  localparam int NIBBLES = BCD_BITS / dlrs_pkg::DIGIT_BITS;

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [BCD_BITS-1:0]   adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    adj = bcd_q;
    for (int n = 0; n < NIBBLES; n++) begin
      if (bcd_q[4*n +: 4] >= 4'd5) begin
        adj[4*n +: 4] = bcd_q[4*n +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(VALUE_BITS);
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q && (step_q != '0)) begin
      step_d = step_q - STEP_W'(1);
      bin_d  = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d  = {adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = busy_q && (step_q == '0);
  assign bcd_o  = bcd_q;

endmodule

FILE: hw/rtl/decimal_lsd_radix_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal LSD radix sorter
// Collects values, sorts them with a stable base-10 LSD radix sort on the
// first fetch and returns them one per fetch in ascending order.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                    tuser                tlast
//  s_axis    in   value                    req_type (0 load)    -
//  m_axis    out  sorted_value             valid_res            is_last
//
// A load runs the value through the binary to BCD converter, which handles one
// bit a cycle, and the value is stored together with its BCD digits.
// A fetch reads through the registered memory read port. The first fetch
// after loads also runs the sort: one pass per decimal digit of the largest
// value (check, count, prefix sum, scatter into the other buffer, which then
// becomes the current one), and one closing check.
// Reset clears all control state; the element memories need no clearing.
// A waiting result does not block loads; a fetch waits until it can be shown.
module decimal_lsd_radix_sort #(
  parameter int MAX_ELEMENTS = dlrs_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = dlrs_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [VALUE_BITS-1:0] value, zero padding above
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [VALUE_BITS-1:0] sorted_value, zero padding above
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
  // [0] valid_res
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS = dlrs_pkg::DIGIT_BITS * DIGITS;
  localparam int MEM_W    = VALUE_BITS + BCD_BITS;
  localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int PASS_W   = $clog2(DIGITS + 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CONV      = 3'd1;
  localparam logic [2:0] ST_CHECK     = 3'd2;
  localparam logic [2:0] ST_COUNT     = 3'd3;
  localparam logic [2:0] ST_PREFIX    = 3'd4;
  localparam logic [2:0] ST_SCATTER   = 3'd5;
  localparam logic [2:0] ST_FETCH_RD  = 3'd6;
  localparam logic [2:0] ST_FETCH_OUT = 3'd7;

  logic [2:0]            state_q, state_d;
  logic                  cur_q, cur_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [VALUE_BITS-1:0] max_q, max_d;
  logic [BCD_BITS-1:0]   max_bcd_q, max_bcd_d;
  logic [BCD_BITS-1:0]   max_sh_q, max_sh_d;
  logic [PASS_W-1:0]     pass_q, pass_d;
  logic [CNT_W-1:0]      read_q, read_d;
  logic                  sorted_q, sorted_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  dlrs_pkg::digit_t      k_q, k_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]      cnt_q [dlrs_pkg::RADIX];
  logic [CNT_W-1:0]      cnt_d [dlrs_pkg::RADIX];
  logic                  wr_en_q, wr_en_d;
  logic                  new_max_q, new_max_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  out_vld_q, out_vld_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic                  out_last_q, out_last_d;
  logic                  out_res_q, out_res_d;

  // Two element buffers that trade roles after every pass.
  logic [MEM_W-1:0]  mem0 [MAX_ELEMENTS];
  logic [MEM_W-1:0]  mem1 [MAX_ELEMENTS];
  logic [MEM_W-1:0]  rdata0_q, rdata1_q;
  logic [MEM_W-1:0]  rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic              mem_wsel;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  logic                  conv_start;
  logic                  conv_done;
  logic [BCD_BITS-1:0]   conv_bcd;
  logic [VALUE_BITS-1:0] in_value;
  logic [CNT_W-1:0]      eff_count;
  logic [VALUE_BITS-1:0] eff_max;
  logic [BCD_BITS-1:0]   rd_bcd_sh;
  dlrs_pkg::digit_t      dig;
  logic [CNT_W-1:0]      pos;
  logic                  hit;

  assign in_value  = s_axis_tdata[VALUE_BITS-1:0];
  assign eff_count = sorted_q ? '0 : count_q;
  assign eff_max   = sorted_q ? '0 : max_q;
  assign rdata     = cur_q ? rdata1_q : rdata0_q;
  assign rd_bcd_sh = rdata[MEM_W-1:VALUE_BITS] >> {pass_q, 2'b00};
  assign dig       = rd_bcd_sh[dlrs_pkg::DIGIT_BITS-1:0];
  assign pos       = cnt_q[dig] - CNT_W'(1);
  assign hit       = read_q < count_q;

  dlrs_bcd_conv #(
    .VALUE_BITS (VALUE_BITS),
    .BCD_BITS   (BCD_BITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (in_value),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    count_d    = count_q;
    max_d      = max_q;
    max_bcd_d  = max_bcd_q;
    max_sh_d   = max_sh_q;
    pass_d     = pass_q;
    read_d     = read_q;
    sorted_d   = sorted_q;
    idx_d      = idx_q;
    k_d        = k_q;
    rd_vld_d   = 1'b0;
    cnt_d      = cnt_q;
    wr_en_d    = wr_en_q;
    new_max_d  = new_max_q;
    val_d      = val_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    out_res_d  = out_res_q;
    conv_start = 1'b0;
    rd_addr    = read_q[ADDR_W-1:0];
    mem_we     = 1'b0;
    mem_wsel   = cur_q;
    mem_waddr  = count_q[ADDR_W-1:0];
    mem_wdata  = {conv_bcd, val_q};

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == dlrs_pkg::REQ_LOAD) begin
            // A load after any fetch opens a new set.
            if (sorted_q) begin
              count_d   = '0;
              max_d     = '0;
              max_bcd_d = '0;
              read_d    = '0;
              sorted_d  = 1'b0;
            end
            wr_en_d    = eff_count < CNT_W'(MAX_ELEMENTS);
            new_max_d  = wr_en_d && (in_value > eff_max);
            if (new_max_d) begin
              max_d = in_value;
            end
            val_d      = in_value;
            conv_start = 1'b1;
            state_d    = ST_CONV;
          end else if (!sorted_q) begin
            max_sh_d = max_bcd_q;
            pass_d   = '0;
            state_d  = ST_CHECK;
          end else begin
            state_d = ST_FETCH_RD;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          if (wr_en_q) begin
            mem_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (new_max_q) begin
              max_bcd_d = conv_bcd;
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        // Another pass is needed while the largest value has digits left.
        if (max_sh_q != '0) begin
          for (int d = 0; d < dlrs_pkg::RADIX; d++) begin
            cnt_d[d] = '0;
          end
          idx_d   = '0;
          state_d = ST_COUNT;
        end else begin
          sorted_d = 1'b1;
          read_d   = '0;
          state_d  = ST_FETCH_RD;
        end
      end
      ST_COUNT: begin
        if (idx_q != count_q) begin
          rd_addr  = idx_q[ADDR_W-1:0];
          idx_d    = idx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          cnt_d[dig] = cnt_q[dig] + CNT_W'(1);
        end
        if ((idx_q == count_q) && !rd_vld_q) begin
          k_d     = dlrs_pkg::digit_t'(1);
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        cnt_d[k_q] = cnt_q[k_q] + cnt_q[k_q - dlrs_pkg::digit_t'(1)];
        if (k_q == dlrs_pkg::digit_t'(dlrs_pkg::RADIX - 1)) begin
          state_d = ST_SCATTER;
        end else begin
          k_d = k_q + dlrs_pkg::digit_t'(1);
        end
      end
      ST_SCATTER: begin
        // Walk from the last element down so that equal digits keep order.
        if (idx_q != '0) begin
          rd_addr  = ADDR_W'(idx_q - CNT_W'(1));
          idx_d    = idx_q - CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          cnt_d[dig] = pos;
          mem_we     = 1'b1;
          mem_wsel   = !cur_q;
          mem_waddr  = pos[ADDR_W-1:0];
          mem_wdata  = rdata;
        end
        if ((idx_q == '0) && !rd_vld_q) begin
          cur_d    = !cur_q;
          max_sh_d = max_sh_q >> dlrs_pkg::DIGIT_BITS;
          pass_d   = pass_q + PASS_W'(1);
          state_d  = ST_CHECK;
        end
      end
      ST_FETCH_RD: begin
        state_d = ST_FETCH_OUT;
      end
      ST_FETCH_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_val_d  = hit ? rdata[VALUE_BITS-1:0] : '0;
          out_last_d = hit && ((read_q + CNT_W'(1)) == count_q);
          out_res_d  = hit;
          if (hit) begin
            read_d = read_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= 1'b0;
      count_q   <= '0;
      max_q     <= '0;
      max_bcd_q <= '0;
      max_sh_q  <= '0;
      pass_q    <= '0;
      read_q    <= '0;
      sorted_q  <= 1'b0;
      idx_q     <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      wr_en_q   <= 1'b0;
      new_max_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int d = 0; d < dlrs_pkg::RADIX; d++) begin
        cnt_q[d] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      count_q   <= count_d;
      max_q     <= max_d;
      max_bcd_q <= max_bcd_d;
      max_sh_q  <= max_sh_d;
      pass_q    <= pass_d;
      read_q    <= read_d;
      sorted_q  <= sorted_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      wr_en_q   <= wr_en_d;
      new_max_q <= new_max_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_res_q  <= out_res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && !mem_wsel) begin
      mem0[mem_waddr] <= mem_wdata;
    end
    rdata0_q <= mem0[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && mem_wsel) begin
      mem1[mem_waddr] <= mem_wdata;
    end
    rdata1_q <= mem1[rd_addr];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DATA_W'(out_val_q);
  assign m_axis_tuser  = out_res_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hw/rtl/dlrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal LSD radix sorter checker
// Port-level assertions on the sorter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dlrs_checker #(
  parameter int DATA_W = 32
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [DATA_W-1:0] s_axis_tdata,
  input logic              s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast
);

  logic in_beat;
  logic out_beat;
  logic past_last_q;
  logic stale_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Set once the final value of a set has gone out; a load starts a new set.
  // A result still waiting when a load is taken belongs to the older set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_last_q <= 1'b0;
      stale_q     <= 1'b0;
    end else if (in_beat && (s_axis_tuser == dlrs_pkg::REQ_LOAD)) begin
      past_last_q <= 1'b0;
      stale_q     <= m_axis_tvalid && !m_axis_tready;
    end else if (out_beat) begin
      stale_q <= 1'b0;
      if (m_axis_tlast && !stale_q) begin
        past_last_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("fetch past the end carries data or last");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && past_last_q |-> !m_axis_tuser)
    else $error("value returned after the last one of the set");

endmodule

bind decimal_lsd_radix_sort dlrs_checker #(
  .DATA_W (DATA_W)
) u_dlrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
